### rtl/rta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rta_pkg;

  localparam int OP_W        = 2;
  localparam int IDX_IN_W    = 16;
  localparam int BLOCK_W     = 64;
  localparam int FLAGS_IN_W  = 16;
  localparam int STATUS_W    = 3;
  localparam int REC_OUT_W   = 10;
  localparam int GEN_W       = 32;
  localparam int FREE_W      = 16;
  localparam int CAP_CFG_W   = 11;
  localparam int CAP_CFG_RST = 1024;

  localparam logic [BLOCK_W-1:0] BLOCK_UNBOUND = {BLOCK_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_UPDATE  = 2'd1,
    OP_FREE    = 2'd2,
    OP_RESOLVE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_UNBOUND   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_DATA
  } state_t;

endpackage

`default_nettype wire

### rtl/rta_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/rta_find.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-level registered priority search: the first stage finds the lowest
// set bit in each group, the second picks the lowest group that has one.
module rta_find #(
  parameter int N = 1024
) (
  input  wire logic                 clk,
  input  wire logic [N-1:0]         cand,
  output logic                      found,
  output logic [$clog2(N)-1:0]      index
);

  localparam int IDX_W = $clog2(N);
  localparam int GRP_W = (IDX_W + 1) / 2;
  localparam int GRP   = 1 << GRP_W;
  localparam int NG    = (N + GRP - 1) / GRP;
  localparam int NG_W  = (NG > 1) ? $clog2(NG) : 1;

  logic [NG*GRP-1:0] cand_pad;
  logic [NG-1:0]     any_nxt, any_r;
  logic [GRP_W-1:0]  off_nxt [NG];
  logic [GRP_W-1:0]  off_r   [NG];
  logic              found_nxt;
  logic [IDX_W-1:0]  index_nxt;
  logic [NG_W-1:0]   sel;

  assign cand_pad = (NG*GRP)'(cand);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      any_nxt[g] = |cand_pad[g*GRP +: GRP];
      off_nxt[g] = '0;
      for (int b = GRP - 1; b >= 0; b--) begin
        if (cand_pad[g*GRP + b]) begin
          off_nxt[g] = GRP_W'(b);
        end
      end
    end
  end

  always_comb begin
    sel = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (any_r[g]) begin
        sel = NG_W'(g);
      end
    end
    found_nxt = |any_r;
    index_nxt = IDX_W'(32'(sel) * GRP + 32'(off_r[sel]));
  end

  always_ff @(posedge clk) begin
    any_r <= any_nxt;
    off_r <= off_nxt;
    found <= found_nxt;
    index <= index_nxt;
  end

endmodule

`default_nettype wire

### rtl/record_table_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                                  Handshake
// input     in_op, in_record_index, in_new_block, in_flags_in      start & !busy
// result    out_status, out_record_out, out_block_out,             out_valid, one cycle
//           out_flags_out, out_generation_out, out_free_left
// config    cfg_table_capacity                                     cfg_valid & cfg_ready
//
// Update, free and resolve read the record memory, then modify, write back and
// register the result word in S_DATA. Allocate first runs the registered two-level
// first-free search through S_SCAN and S_PICK.
// After reset a clearing pass writes every record with busy high; configuration
// writes are taken during it and in idle cycles without a start.
// The result is shown for one cycle and cannot be stalled by the receiver.
module record_table_allocator
  import rta_pkg::*;
#(
  parameter int MAX_RECORDS = 1024,
  parameter int FLAG_BITS   = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [OP_W-1:0]       in_op,
  input  wire logic [IDX_IN_W-1:0]   in_record_index,
  input  wire logic [BLOCK_W-1:0]    in_new_block,
  input  wire logic [FLAGS_IN_W-1:0] in_flags_in,
  output logic                       out_valid,
  output logic [STATUS_W-1:0]        out_status,
  output logic [REC_OUT_W-1:0]       out_record_out,
  output logic [BLOCK_W-1:0]         out_block_out,
  output logic [FLAGS_IN_W-1:0]      out_flags_out,
  output logic [GEN_W-1:0]           out_generation_out,
  output logic [FREE_W-1:0]          out_free_left,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CAP_CFG_W-1:0]  cfg_table_capacity
);

  localparam int IDX_W   = $clog2(MAX_RECORDS);
  localparam int CAP_W   = $clog2(MAX_RECORDS + 1);
  localparam int REC_W   = BLOCK_W + FLAG_BITS + GEN_W;
  localparam int CAP_RST = (CAP_CFG_RST > MAX_RECORDS) ? MAX_RECORDS : CAP_CFG_RST;
  localparam logic [FREE_W-1:0] FREE_RST  = FREE_W'(CAP_RST - 1);
  localparam logic [IDX_W-1:0]  LAST_ADDR = IDX_W'(MAX_RECORDS - 1);
  localparam logic [REC_W-1:0]  REC_RST   = {BLOCK_UNBOUND, {FLAG_BITS{1'b0}}, {GEN_W{1'b0}}};

  state_t state_r, state_nxt;

  logic [CAP_CFG_W-1:0] cap_cfg_r;
  logic [CAP_W-1:0]     cap_live;
  logic [FREE_W-1:0]    free_cnt_r, free_cnt_nxt;
  logic [IDX_W-1:0]     clr_addr_r;
  logic [MAX_RECORDS-1:0] alloc_r;
  logic [MAX_RECORDS-1:0] cand;

  op_t                  op_r;
  logic [IDX_W-1:0]     idx_r;
  logic                 idx_ok_r;
  logic [BLOCK_W-1:0]   blk_r;
  logic [FLAG_BITS-1:0] flg_r;
  logic                 found_r;
  logic [IDX_W-1:0]     pick_r;

  logic                 fnd_found;
  logic [IDX_W-1:0]     fnd_index;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [REC_W-1:0]     ram_wdata, ram_rdata;
  logic [BLOCK_W-1:0]   rd_blk;
  logic [FLAG_BITS-1:0] rd_flg;
  logic [GEN_W-1:0]     rd_gen;

  logic                 accept, cfg_wr;
  logic                 rec_we, set_alloc, clr_alloc;
  logic [IDX_W-1:0]     rec_addr;
  logic [REC_W-1:0]     rec_data;
  status_t              res_status;
  logic [REC_OUT_W-1:0] res_rec;
  logic [BLOCK_W-1:0]   res_blk;
  logic [FLAG_BITS-1:0] res_flg;
  logic [GEN_W-1:0]     res_gen;

  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [REC_OUT_W-1:0] out_rec_r;
  logic [BLOCK_W-1:0]   out_blk_r;
  logic [FLAGS_IN_W-1:0] out_flg_r;
  logic [GEN_W-1:0]     out_gen_r;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  // The capacity only changes while no word is in flight or being taken.
  assign cfg_ready = (state_r == S_CLEAR) || ((state_r == S_IDLE) && !start);
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign cap_live = (32'(cap_cfg_r) > MAX_RECORDS) ? CAP_W'(MAX_RECORDS) : CAP_W'(cap_cfg_r);

  // Records that allocate may hand out: free, not record zero, below capacity.
  always_comb begin
    for (int i = 0; i < MAX_RECORDS; i++) begin
      cand[i] = !alloc_r[i] && (i != 0) && (32'(i) < 32'(cap_live));
    end
  end

  rta_find #(
    .N (MAX_RECORDS)
  ) u_find (
    .clk   (clk),
    .cand  (cand),
    .found (fnd_found),
    .index (fnd_index)
  );

  assign ram_raddr = (state_r == S_PICK) ? fnd_index : in_record_index[IDX_W-1:0];
  assign ram_we    = (state_r == S_CLEAR) || rec_we;
  assign ram_waddr = (state_r == S_CLEAR) ? clr_addr_r : rec_addr;
  assign ram_wdata = (state_r == S_CLEAR) ? REC_RST : rec_data;

  rta_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign {rd_blk, rd_flg, rd_gen} = ram_rdata;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = (op_t'(in_op) == OP_ALLOC) ? S_SCAN : S_DATA;
        end
      end
      S_SCAN:  state_nxt = S_PICK;
      S_PICK:  state_nxt = S_DATA;
      S_DATA:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Read-modify-write of the addressed record and the result word.
  always_comb begin
    rec_we       = 1'b0;
    set_alloc    = 1'b0;
    clr_alloc    = 1'b0;
    rec_addr     = idx_r;
    rec_data     = ram_rdata;
    res_status   = ST_OK;
    res_rec      = '0;
    res_blk      = '0;
    res_flg      = '0;
    res_gen      = '0;
    free_cnt_nxt = free_cnt_r;
    if (state_r == S_DATA) begin
      if (op_r == OP_ALLOC) begin
        rec_addr = pick_r;
        if (found_r) begin
          rec_we       = 1'b1;
          set_alloc    = 1'b1;
          rec_data     = {BLOCK_UNBOUND, rd_flg | FLAG_BITS'(1), rd_gen + GEN_W'(1)};
          res_rec      = REC_OUT_W'(pick_r);
          res_gen      = rd_gen + GEN_W'(1);
          free_cnt_nxt = free_cnt_r - FREE_W'(1);
        end else begin
          res_status = ST_NO_SPACE;
        end
      end else if (!idx_ok_r) begin
        res_status = ST_INVALID;
      end else begin
        case (op_r)
          OP_UPDATE: begin
            rec_we    = 1'b1;
            set_alloc = flg_r[0];
            rec_data  = {blk_r, rd_flg | flg_r, rd_gen};
          end
          OP_FREE: begin
            rec_we       = 1'b1;
            clr_alloc    = 1'b1;
            rec_data     = {BLOCK_UNBOUND, {FLAG_BITS{1'b0}}, rd_gen};
            free_cnt_nxt = free_cnt_r + FREE_W'(1);
          end
          default: begin
            if (!rd_flg[0]) begin
              res_status = ST_NOT_FOUND;
            end else if (rd_blk == '0 || rd_blk == BLOCK_UNBOUND) begin
              res_status = ST_UNBOUND;
            end else begin
              res_blk = rd_blk;
              res_flg = rd_flg;
              res_gen = rd_gen;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      cap_cfg_r   <= CAP_CFG_W'(CAP_CFG_RST);
      free_cnt_r  <= FREE_RST;
      alloc_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_DATA);
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + IDX_W'(1);
      end
      if (cfg_wr) begin
        cap_cfg_r  <= cfg_table_capacity;
        free_cnt_r <= FREE_W'(32'((32'(cfg_table_capacity) > MAX_RECORDS)
                                  ? MAX_RECORDS : 32'(cfg_table_capacity)) - 32'd1);
      end else begin
        free_cnt_r <= free_cnt_nxt;
      end
      if (set_alloc) begin
        alloc_r[rec_addr] <= 1'b1;
      end else if (clr_alloc) begin
        alloc_r[rec_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= op_t'(in_op);
      idx_r    <= in_record_index[IDX_W-1:0];
      idx_ok_r <= (32'(in_record_index) < 32'(cap_live));
      blk_r    <= in_new_block;
      flg_r    <= in_flags_in[FLAG_BITS-1:0];
    end
    if (state_r == S_PICK) begin
      found_r <= fnd_found;
      pick_r  <= fnd_index;
    end
    if (state_r == S_DATA) begin
      out_status_r <= res_status;
      out_rec_r    <= res_rec;
      out_blk_r    <= res_blk;
      out_flg_r    <= FLAGS_IN_W'(res_flg);
      out_gen_r    <= res_gen;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_record_out     = out_rec_r;
  assign out_block_out      = out_blk_r;
  assign out_flags_out      = out_flg_r;
  assign out_generation_out = out_gen_r;
  assign out_free_left      = free_cnt_r;

  // A successful allocate never hands out record zero or a record at or above capacity.
  a_alloc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DATA && op_r == OP_ALLOC && found_r) |->
      (pick_r != '0 && 32'(pick_r) < 32'(cap_live)))
    else $error("allocate picked a record outside the usable range");

  // The free count moves only with a result or a capacity write.
  a_free_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_DATA && !cfg_wr) |=> $stable(free_cnt_r))
    else $error("free count changed without an operation");

  // A result word follows in the cycle after the modify cycle.
  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DATA) |=> out_valid)
    else $error("result word missing after modify cycle");

  // The allocated vector mirrors bit 0 of the record read back.
  a_alloc_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DATA && op_r != OP_ALLOC && idx_ok_r) |->
      (alloc_r[idx_r] == rd_flg[0]))
    else $error("allocated vector disagrees with record flags");

endmodule

`default_nettype wire
